// ===== rtl/hcmm_pkg.sv =====
package hcmm_pkg;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] DMA_NONE = 2'd0;
    localparam logic [1:0] DMA_OAM  = 2'd1;
    localparam logic [1:0] DMA_VRAM = 2'd2;

    localparam logic [0:0] CFG_CGB_MODE = 1'd0;
    localparam logic [0:0] CFG_CART_RAM = 1'd1;

    // IO register offsets within 0xFF00-0xFF7F.
    localparam logic [6:0] IO_DIV  = 7'h04;
    localparam logic [6:0] IO_LCDC = 7'h40;
    localparam logic [6:0] IO_STAT = 7'h41;
    localparam logic [6:0] IO_LY   = 7'h44;
    localparam logic [6:0] IO_DMA  = 7'h46;
    localparam logic [6:0] IO_KEY1 = 7'h4D;
    localparam logic [6:0] IO_VBK  = 7'h4F;
    localparam logic [6:0] IO_HDMA = 7'h55;
    localparam logic [6:0] IO_BCPS = 7'h68;
    localparam logic [6:0] IO_BCPD = 7'h69;
    localparam logic [6:0] IO_OCPS = 7'h6A;
    localparam logic [6:0] IO_OCPD = 7'h6B;
    localparam logic [6:0] IO_OPRI = 7'h6C;
    localparam logic [6:0] IO_SVBK = 7'h70;
    localparam logic [6:0] IO_R74  = 7'h74;
    localparam logic [6:0] IO_R75  = 7'h75;

    localparam logic [7:0] LY_OFF = 8'd153;

    typedef struct packed {
        logic [7:0] read_data;
        logic       to_cartridge;
        logic       lcd_off_event;
        logic [1:0] dma_request;
        logic [7:0] dma_value;
    } t_result;

endpackage

// ===== rtl/hcmm_ram.sv =====
module hcmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/handheld_console_memory_map_core.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   command, address, write_data
// m_axis    out  m_axis_tvalid/m_axis_tready   read_data, to_cartridge, lcd_off_event,
//                                              dma_request, dma_value
// cfg       in   i_cfg_valid/o_cfg_ready       register index, write data
//
// Every access has an idle and an execute phase. In the idle cycle the access is accepted
// and the addressed memories are read. In the execute cycle the one memory the access
// touches is modified and written back, and the output register is loaded.
// After reset a clearing pass zeroes the RAMs and sets the palette to 0xFF; no transfer
// is accepted during it. The next access is accepted once the previous result has left
// the output register or is being taken, so a stalled output holds at most one finished
// result.
module handheld_console_memory_map_core
    import hcmm_pkg::*;
#(
    parameter int WORK_BANKS  = 8,
    parameter int VIDEO_BANKS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] command, [16:1] address, [24:17] write_data, [31:25] zero
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [8] to_cartridge, [9] lcd_off_event, [11:10] dma_request,
    // [19:12] dma_value, [23:20] zero
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic        i_cfg_data
);
    localparam int VDEPTH = VIDEO_BANKS * 8192;
    localparam int WDEPTH = WORK_BANKS * 4096;
    localparam int VAW    = $clog2(VDEPTH);
    localparam int WAW    = $clog2(WDEPTH);
    localparam int CLRN   = (WDEPTH > VDEPTH) ? WDEPTH : VDEPTH;
    localparam int CAW    = $clog2(CLRN + 1);

    // Phase codes.
    localparam logic [1:0] PH_CLEAR = 2'd0;
    localparam logic [1:0] PH_IDLE  = 2'd1;
    localparam logic [1:0] PH_EXEC  = 2'd2;

    logic [1:0]     r_ph, n_ph;
    logic [CAW-1:0] r_clr;
    logic           r_cgb, r_cart;
    logic           r_vbank;
    logic [2:0]     r_wbank;
    logic           r_cmd;
    logic [15:0]    r_addr;
    logic [7:0]     r_wd;
    logic           r_ovalid;
    t_result        r_res, n_res;

    logic       acc;
    logic       in_cmd;
    logic [15:0] in_addr;
    logic [7:0] in_wd;
    assign in_cmd  = s_axis_tdata[0];
    assign in_addr = s_axis_tdata[16:1];
    assign in_wd   = s_axis_tdata[24:17];

    assign s_axis_tready = (r_ph == PH_IDLE) && (!r_ovalid || m_axis_tready);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {4'd0, r_res.dma_value, r_res.dma_request,
                           r_res.lcd_off_event, r_res.to_cartridge, r_res.read_data};

    // Address decode, for read addresses from the accepted input and write addresses latched.
    function automatic logic [VAW-1:0] vidx(input logic [15:0] a, input logic cgb,
                                             input logic vb);
        logic [31:0] b;
        b = (cgb && VIDEO_BANKS > 1) ? {31'd0, vb} : 32'd0;
        return VAW'(b * 8192 + {19'd0, a[12:0]});
    endfunction

    function automatic logic [WAW-1:0] widx(input logic [15:0] a, input logic cgb,
                                             input logic [2:0] wb);
        logic [3:0] b;
        b = cgb ? {1'b0, wb} : 4'd1;
        // Fold the bank number into the banks that exist.
        for (int k = 0; k < 4; k++) begin
            if (b >= 4'(WORK_BANKS)) b = 4'(b - 4'(WORK_BANKS));
        end
        if (!a[12]) return WAW'({20'd0, a[11:0]});
        return WAW'({16'd0, b, a[11:0]});
    endfunction

    // Region flags of the latched access.
    logic rg_rom, rg_vram, rg_cram, rg_wram, rg_echo, rg_oam, rg_io, rg_hram;
    assign rg_rom  = r_addr <= 16'h7FFF;
    assign rg_vram = !rg_rom && r_addr <= 16'h9FFF;
    assign rg_cram = r_addr >= 16'hA000 && r_addr <= 16'hBFFF;
    assign rg_wram = r_addr >= 16'hC000 && r_addr <= 16'hDFFF;
    assign rg_echo = r_addr >= 16'hE000 && r_addr <= 16'hFDFF;
    assign rg_oam  = r_addr >= 16'hFE00 && r_addr <= 16'hFE9F;
    assign rg_io   = r_addr >= 16'hFF00 && r_addr <= 16'hFF7F;
    assign rg_hram = r_addr >= 16'hFF80;

    logic [6:0] reg_a;
    assign reg_a = r_addr[6:0];

    // Memories.
    logic           v_we, w_we, o_we, i_we, h_we, p_we;
    logic [VAW-1:0] v_wa, v_ra;
    logic [WAW-1:0] w_wa, w_ra;
    logic [7:0]     o_wa, o_ra;
    logic [6:0]     i_wa, i_ra, h_wa, h_ra, p_wa, p_ra;
    logic [7:0]     v_wd, w_wd, o_wd, i_wd, h_wd, p_wd;
    logic [7:0]     v_rd, w_rd, o_rd, i_rd, h_rd, p_rd;

    // Palette index registers live in flops since a palette access needs them
    // before the palette read.
    logic [7:0] r_bcps, r_ocps;
    logic [7:0] r_lcdc;

    logic clr;
    assign clr = (r_ph == PH_CLEAR);

    always_comb begin
        v_ra = vidx(in_addr, r_cgb, r_vbank);
        w_ra = widx(in_addr, r_cgb, r_wbank);
        o_ra = 8'(in_addr[7:0]);
        i_ra = in_addr[6:0];
        h_ra = in_addr[6:0];
        p_ra = (in_addr[6:0] == IO_OCPD) ? {1'b1, r_ocps[5:0]} : {1'b0, r_bcps[5:0]};
    end

    logic ex, wr;
    assign ex = (r_ph == PH_EXEC);
    assign wr = ex && r_cmd == CMD_WRITE;

    logic [7:0] io_new;
    logic       io_we;
    always_comb begin
        io_new = r_wd;
        io_we  = 1'b1;
        unique case (reg_a)
            IO_DIV:  io_new = 8'd0;
            IO_STAT: io_new = {r_wd[7:3], i_rd[2:0]};
            IO_LY:   io_we = 1'b0;
            IO_KEY1: io_new = {i_rd[7:1], r_wd[0]};
            IO_VBK:  begin io_we = r_cgb; io_new = {7'd0, r_wd[0]}; end
            IO_HDMA: io_we = 1'b0;
            IO_BCPD: io_we = 1'b0;
            IO_OCPD: io_we = 1'b0;
            IO_OPRI: begin io_we = r_cgb; io_new = {i_rd[7:1], r_wd[0]}; end
            IO_SVBK: begin io_we = r_cgb; io_new = {5'd0, r_wd[2:0]}; end
            IO_R74:  io_we = r_cgb;
            IO_R75:  io_new = r_wd & 8'h70;
            default: io_new = r_wd;
        endcase
    end

    logic lcd_off;
    assign lcd_off = wr && rg_io && reg_a == IO_LCDC && r_lcdc[7] && !r_wd[7];

    function automatic logic [7:0] adv(input logic [7:0] x);
        return x[7] ? {x[7:6], 6'(x[5:0] + 6'd1)} : x;
    endfunction

    always_comb begin
        v_we = clr || (wr && rg_vram);
        v_wa = clr ? VAW'(r_clr) : vidx(r_addr, r_cgb, r_vbank);
        v_wd = clr ? 8'd0 : r_wd;
        w_we = clr || (wr && rg_wram);
        w_wa = clr ? WAW'(r_clr) : widx(r_addr, r_cgb, r_wbank);
        w_wd = clr ? 8'd0 : r_wd;
        o_we = clr || (wr && rg_oam);
        o_wa = clr ? r_clr[7:0] : 8'(r_addr[7:0]);
        o_wd = clr ? 8'd0 : r_wd;
        h_we = clr || (wr && rg_hram);
        h_wa = clr ? r_clr[6:0] : r_addr[6:0];
        h_wd = clr ? 8'd0 : r_wd;
        p_we = clr || (wr && rg_io && (reg_a == IO_BCPD || reg_a == IO_OCPD));
        p_wa = clr ? r_clr[6:0] :
               ((reg_a == IO_OCPD) ? {1'b1, r_ocps[5:0]} : {1'b0, r_bcps[5:0]});
        p_wd = clr ? 8'hFF : r_wd;
        i_we = clr || (wr && rg_io && (io_we || lcd_off));
        i_wa = clr ? r_clr[6:0] : (lcd_off ? IO_LY : reg_a);
        i_wd = clr ? 8'd0 : (lcd_off ? LY_OFF : io_new);
    end

    // LCDC is written as a flop and in the register file, LY goes to the file on
    // an LCD-off write (LCDC then lands through its own shadow).
    hcmm_ram #(.WIDTH(8), .DEPTH(VDEPTH)) u_vram (.i_clk, .i_we(v_we), .i_waddr(v_wa),
        .i_wdata(v_wd), .i_raddr(v_ra), .o_rdata(v_rd));
    hcmm_ram #(.WIDTH(8), .DEPTH(WDEPTH)) u_wram (.i_clk, .i_we(w_we), .i_waddr(w_wa),
        .i_wdata(w_wd), .i_raddr(w_ra), .o_rdata(w_rd));
    hcmm_ram #(.WIDTH(8), .DEPTH(256)) u_oam (.i_clk, .i_we(o_we), .i_waddr(o_wa),
        .i_wdata(o_wd), .i_raddr(o_ra), .o_rdata(o_rd));
    hcmm_ram #(.WIDTH(8), .DEPTH(128)) u_io (.i_clk, .i_we(i_we), .i_waddr(i_wa),
        .i_wdata(i_wd), .i_raddr(i_ra), .o_rdata(i_rd));
    hcmm_ram #(.WIDTH(8), .DEPTH(128)) u_hram (.i_clk, .i_we(h_we), .i_waddr(h_wa),
        .i_wdata(h_wd), .i_raddr(h_ra), .o_rdata(h_rd));
    hcmm_ram #(.WIDTH(8), .DEPTH(128)) u_pal (.i_clk, .i_we(p_we), .i_waddr(p_wa),
        .i_wdata(p_wd), .i_raddr(p_ra), .o_rdata(p_rd));

    // Result.
    always_comb begin
        n_res = '0;
        if (ex) begin
            if (rg_rom || (rg_cram && r_cart)) begin
                n_res.to_cartridge = 1'b1;
            end else if (r_cmd == CMD_READ) begin
                priority if (rg_vram) n_res.read_data = v_rd;
                else if (rg_cram) n_res.read_data = 8'hFF;
                else if (rg_wram || rg_echo) n_res.read_data = w_rd;
                else if (rg_oam) n_res.read_data = o_rd;
                else if (rg_io) begin
                    priority if (reg_a == IO_BCPD || reg_a == IO_OCPD)
                        n_res.read_data = p_rd;
                    else if (reg_a == IO_BCPS) n_res.read_data = r_bcps;
                    else if (reg_a == IO_OCPS) n_res.read_data = r_ocps;
                    else if (reg_a == IO_LCDC) n_res.read_data = r_lcdc;
                    else n_res.read_data = i_rd;
                end
                else if (rg_hram) n_res.read_data = h_rd;
                else n_res.read_data = 8'd0;
            end
            if (wr && rg_io) begin
                n_res.lcd_off_event = lcd_off;
                if (reg_a == IO_DMA) begin
                    n_res.dma_request = DMA_OAM;
                    n_res.dma_value   = r_wd;
                end else if (reg_a == IO_HDMA && r_cgb) begin
                    n_res.dma_request = DMA_VRAM;
                    n_res.dma_value   = r_wd;
                end
            end
        end
    end

    always_comb begin
        n_ph = r_ph;
        unique case (r_ph)
            PH_CLEAR: if (r_clr == CAW'(CLRN - 1)) n_ph = PH_IDLE;
            PH_IDLE:  if (acc) n_ph = PH_EXEC;
            PH_EXEC:  n_ph = PH_IDLE;
            default:  n_ph = PH_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph     <= PH_CLEAR;
            r_clr    <= '0;
            r_cgb    <= 1'b0;
            r_cart   <= 1'b0;
            r_vbank  <= 1'b0;
            r_wbank  <= 3'd1;
            r_ovalid <= 1'b0;
            r_bcps   <= 8'd0;
            r_ocps   <= 8'd0;
            r_lcdc   <= 8'd0;
        end else begin
            r_ph <= n_ph;
            if (clr) r_clr <= CAW'(r_clr + 1'b1);
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_CGB_MODE) r_cgb <= i_cfg_data;
                else r_cart <= i_cfg_data;
            end
            if (ex) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            if (wr && rg_io) begin
                unique case (reg_a)
                    IO_LCDC: r_lcdc <= r_wd;
                    IO_VBK:  if (r_cgb) r_vbank <= r_wd[0];
                    IO_SVBK: if (r_cgb) r_wbank <= (r_wd[2:0] != 3'd0) ? r_wd[2:0] : 3'd1;
                    IO_BCPS: r_bcps <= r_wd;
                    IO_OCPS: r_ocps <= r_wd;
                    IO_BCPD: r_bcps <= adv(r_bcps);
                    IO_OCPD: r_ocps <= adv(r_ocps);
                    default: r_lcdc <= r_lcdc;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cmd  <= in_cmd;
            r_addr <= in_addr;
            r_wd   <= in_wd;
        end
        if (ex) r_res <= n_res;
    end

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr |-> !s_axis_tready) else $error("accept during clear");
    a_exec_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> ex) else $error("exec missing");
    a_out_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ex |=> m_axis_tvalid) else $error("result missing");
    a_cart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_res.to_cartridge) |-> r_res.read_data == 8'd0)
        else $error("cart read data");
`endif
endmodule
